// ----- src/bmhq_pkg.sv -----
// Shared types and codes for the binary min-heap priority queue.
// No dependencies; imported by binary_min_heap_queue.
package bmhq_pkg;

  // Request codes carried on req_type.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } bmhq_status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_DN_LAST,
    ST_DN_CHK,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_FIN
  } bmhq_state_t;

endpackage

// ----- src/bmhq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the heap array of binary_min_heap_queue.
module bmhq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/binary_min_heap_queue.sv -----
// Binary min-heap priority queue: top level with its sift sequencer.
// Depends on bmhq_pkg (types, codes) and bmhq_ram (heap array).
//
//   channel  | signals                                      | direction
//   ---------+----------------------------------------------+----------
//   request  | in_valid, in_stall, req_type, entry_key,     | in
//            | entry_handle                                 |
//   result   | out_valid, out_stall, out_key, out_handle,   | out
//            | entry_count, status                          |
//
// A push walks up from its new leaf with a parent read and compare per level; a pop
// fetches the last entry, then walks down from the root reading both children per level.
// The sift pace is bounded by the single RAM read port, and a new request is taken only
// once the sequencer is back in idle. A refused request goes straight to the finish step.
// Reset clears the count, out_valid and the sequencer; the heap array needs no clearing.
// A stalled result holds the sequencer in its finish step, and in_stall stays high meanwhile.
module binary_min_heap_queue
  import bmhq_pkg::*;
#(
  parameter int CAPACITY     = 256,
  parameter int KEY_WIDTH    = 32,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [KEY_WIDTH-1:0]          entry_key,
  input  logic [HANDLE_WIDTH-1:0]       entry_handle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [KEY_WIDTH-1:0]          out_key,
  output logic [HANDLE_WIDTH-1:0]       out_handle,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count,
  output logic [1:0]                    status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;
  localparam int DW = KEY_WIDTH + HANDLE_WIDTH;

  bmhq_state_t state, state_next;
  logic [CW-1:0]           count, count_next;
  logic [AW-1:0]           pos, pos_next;
  logic [AW-1:0]           lchild, lchild_next;
  logic [KEY_WIDTH-1:0]    cur_key, cur_key_next;
  logic [HANDLE_WIDTH-1:0] cur_hdl, cur_hdl_next;
  logic [KEY_WIDTH-1:0]    lkey, lkey_next;
  logic [HANDLE_WIDTH-1:0] lhdl, lhdl_next;
  logic                    req_pop, req_pop_next;
  logic [KEY_WIDTH-1:0]    res_key, res_key_next;
  logic [HANDLE_WIDTH-1:0] res_hdl, res_hdl_next;
  bmhq_status_t            res_status, res_status_next;
  logic [KEY_WIDTH-1:0]    top_key;
  logic [HANDLE_WIDTH-1:0] top_hdl;
  logic                    out_load;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;

  logic [KEY_WIDTH-1:0]    rd_key;
  logic [HANDLE_WIDTH-1:0] rd_hdl;
  logic [XW-1:0]           count_x;
  logic [XW-1:0]           left_x;
  logic [XW-1:0]           right_x;
  logic [AW-1:0]           parent;
  logic [CW-1:0]           count_dec;
  logic                    take_right;
  logic                    accept;

  bmhq_ram #(
    .WIDTH(DW),
    .DEPTH(CAPACITY)
  ) u_heap_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_key    = rd_data[DW-1:HANDLE_WIDTH];
  assign rd_hdl    = rd_data[HANDLE_WIDTH-1:0];
  assign count_x   = XW'(count);
  assign left_x    = {1'b0, pos, 1'b1};
  assign right_x   = XW'(lchild) + XW'(1);
  assign parent    = (pos - AW'(1)) >> 1;
  assign count_dec = count - CW'(1);
  // The right child exists only below the count; its read data is ignored otherwise.
  assign take_right = (right_x < count_x) && (rd_key <= lkey);

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == ST_FIN) && (!out_valid || !out_stall);

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    lchild_next     = lchild;
    cur_key_next    = cur_key;
    cur_hdl_next    = cur_hdl;
    lkey_next       = lkey;
    lhdl_next       = lhdl;
    req_pop_next    = req_pop;
    res_key_next    = res_key;
    res_hdl_next    = res_hdl;
    res_status_next = res_status;
    wr_en           = 1'b0;
    wr_addr         = pos;
    wr_data         = {cur_key, cur_hdl};
    rd_addr         = left_x[AW-1:0];

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          req_pop_next    = (req_type == REQ_POP);
          res_status_next = STATUS_OK;
          if (req_type == REQ_PUSH) begin
            if (count == CW'(CAPACITY)) begin
              res_status_next = STATUS_FULL;
              state_next      = ST_FIN;
            end else begin
              cur_key_next = entry_key;
              cur_hdl_next = entry_handle;
              pos_next     = count[AW-1:0];
              count_next   = count + CW'(1);
              state_next   = ST_UP_CHK;
            end
          end else begin
            if (count == '0) begin
              res_status_next = STATUS_EMPTY;
              res_key_next    = '0;
              res_hdl_next    = '0;
              state_next      = ST_FIN;
            end else begin
              // Root leaves now; the last entry is fetched to refill it.
              res_key_next = top_key;
              res_hdl_next = top_hdl;
              count_next   = count_dec;
              rd_addr      = count_dec[AW-1:0];
              state_next   = ST_DN_LAST;
            end
          end
        end
      end

      ST_UP_CHK: begin
        if (pos == '0) begin
          wr_en      = 1'b1;
          state_next = ST_FIN;
        end else begin
          rd_addr    = parent;
          state_next = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        wr_en = 1'b1;
        if (rd_key <= cur_key) begin
          state_next = ST_FIN;
        end else begin
          // Parent moves down into the hole and the walk goes up one level.
          wr_data    = rd_data;
          pos_next   = parent;
          state_next = ST_UP_CHK;
        end
      end

      ST_DN_LAST: begin
        cur_key_next = rd_key;
        cur_hdl_next = rd_hdl;
        pos_next     = '0;
        state_next   = ST_DN_CHK;
      end

      ST_DN_CHK: begin
        if (left_x >= count_x) begin
          wr_en      = 1'b1;
          state_next = ST_FIN;
        end else begin
          rd_addr     = left_x[AW-1:0];
          lchild_next = left_x[AW-1:0];
          state_next  = ST_DN_RDR;
        end
      end

      ST_DN_RDR: begin
        lkey_next  = rd_key;
        lhdl_next  = rd_hdl;
        rd_addr    = lchild + AW'(1);
        state_next = ST_DN_CMP;
      end

      ST_DN_CMP: begin
        wr_en = 1'b1;
        if (take_right) begin
          if (cur_key <= rd_key) begin
            state_next = ST_FIN;
          end else begin
            wr_data    = rd_data;
            pos_next   = lchild + AW'(1);
            state_next = ST_DN_CHK;
          end
        end else begin
          if (cur_key <= lkey) begin
            state_next = ST_FIN;
          end else begin
            wr_data    = {lkey, lhdl};
            pos_next   = lchild;
            state_next = ST_DN_CHK;
          end
        end
      end

      ST_FIN: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Sequencer and result registers, plus a shadow of heap entry zero, so the top is known without a RAM read.
  always_ff @(posedge clk) begin
    pos        <= pos_next;
    lchild     <= lchild_next;
    cur_key    <= cur_key_next;
    cur_hdl    <= cur_hdl_next;
    lkey       <= lkey_next;
    lhdl       <= lhdl_next;
    req_pop    <= req_pop_next;
    res_key    <= res_key_next;
    res_hdl    <= res_hdl_next;
    res_status <= res_status_next;
    if (wr_en && (wr_addr == '0)) begin
      top_key <= wr_data[DW-1:HANDLE_WIDTH];
      top_hdl <= wr_data[HANDLE_WIDTH-1:0];
    end
    if (out_load) begin
      out_key     <= req_pop ? res_key : top_key;
      out_handle  <= req_pop ? res_hdl : top_hdl;
      entry_count <= count;
      status      <= res_status;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("heap count exceeds capacity");

  a_write_in_sift: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state != ST_IDLE) && (state != ST_FIN) && (state != ST_DN_LAST))
    else $error("heap write outside a sift step");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (accept && (req_type == REQ_PUSH) && (count != CW'(CAPACITY)))
      |=> (count == $past(count) + CW'(1)))
    else $error("accepted push did not grow the count");

  a_load_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FIN))
    else $error("result loaded outside the finish step");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STATUS_FULL)) |-> (entry_count == CW'(CAPACITY)))
    else $error("full status with a heap that is not full");

endmodule

// ----- tb/binary_min_heap_queue_test.sv -----
// Self-checking testbench for binary_min_heap_queue: directed and random push/pop traffic
// with idling, stalls and back-pressure, checked against an in-bench heap predictor.
// Depends on bmhq_pkg and the binary_min_heap_queue RTL.
module binary_min_heap_queue_test;
  import bmhq_pkg::*;

  localparam int DEPTH     = 256;
  localparam int KW        = 32;
  localparam int HW        = 16;
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int MAX_CYCLES = 600000;
  localparam int TAIL_CYCLES = 40;
  localparam int LONG_HOLD = 300;

  typedef struct {
    logic [KW-1:0] key;
    logic [HW-1:0] handle;
    logic [CW-1:0] count;
    bmhq_status_t  status;
  } heap_result_t;

  // Heap predictor plus the queue of results the block still owes.
  class heap_queue_scoreboard;
    logic [KW-1:0] keys [DEPTH];
    logic [HW-1:0] handles [DEPTH];
    int unsigned   held;
    heap_result_t  owed [$];
    int unsigned   errors;

    function new();
      held = 0;
      errors = 0;
    endfunction

    function void note_request(logic rt, logic [KW-1:0] k, logic [HW-1:0] h);
      heap_result_t r;
      int unsigned pos, up, child, n;
      logic [KW-1:0] mk;
      logic [HW-1:0] mh;
      r.key = '0;
      r.handle = '0;
      r.status = STATUS_OK;
      if (rt == REQ_PUSH) begin
        if (held >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          pos = held;
          while (pos != 0) begin
            up = (pos - 1) >> 1;
            if (keys[up] <= k) break;
            keys[pos] = keys[up];
            handles[pos] = handles[up];
            pos = up;
          end
          keys[pos] = k;
          handles[pos] = h;
          held++;
        end
        if (held != 0) begin
          r.key = keys[0];
          r.handle = handles[0];
        end
      end else if (held == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.key = keys[0];
        r.handle = handles[0];
        held--;
        n = held;
        mk = keys[n];
        mh = handles[n];
        pos = 0;
        // Ties go to the right child; the moved entry stops on a tie.
        while (1'b1) begin
          child = 2 * pos + 1;
          if (child >= n) break;
          if (child + 1 < n && keys[child + 1] <= keys[child]) child = child + 1;
          if (mk <= keys[child]) break;
          keys[pos] = keys[child];
          handles[pos] = handles[child];
          pos = child;
        end
        keys[pos] = mk;
        handles[pos] = mh;
      end
      r.count = held[CW-1:0];
      owed.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_result(logic [KW-1:0] k, logic [HW-1:0] h, logic [CW-1:0] c,
                      logic [1:0] s);
      heap_result_t e;
      if (owed.size() == 0) begin
        report($sformatf("result key=%0h handle=%0h with no request pending", k, h));
        return;
      end
      e = owed.pop_front();
      if (k !== e.key)
        report($sformatf("out_key %0h, predicted %0h", k, e.key));
      if (h !== e.handle)
        report($sformatf("out_handle %0h, predicted %0h", h, e.handle));
      if (c !== e.count)
        report($sformatf("entry_count %0d, predicted %0d", c, e.count));
      if (s !== e.status)
        report($sformatf("status %0d, predicted %0d", s, e.status));
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          req_type = REQ_PUSH;
  logic [KW-1:0] entry_key = '0;
  logic [HW-1:0] entry_handle = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [KW-1:0] out_key;
  logic [HW-1:0] out_handle;
  logic [CW-1:0] entry_count;
  logic [1:0]    status;

  heap_queue_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  long_hold_req = 1'b0;

  binary_min_heap_queue DUT (
    .clk, .rst, .in_valid, .in_stall, .req_type, .entry_key, .entry_handle,
    .out_valid, .out_stall, .out_key, .out_handle, .entry_count, .status
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < MAX_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Result side: checks each transfer and drives out_stall, including the long hold.
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result(out_key, out_handle, entry_count, status);
      if (long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_request(logic rt, logic [KW-1:0] k, logic [HW-1:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    entry_key <= k;
    entry_handle <= h;
    do @(posedge clk); while (in_stall);
    sb.note_request(rt, k, h);
  endtask

  function automatic logic [KW-1:0] pick_key();
    case ($urandom_range(3))
      0: return KW'($urandom_range(15));
      1: return $urandom_range(1) ? '1 : '0;
      default: return KW'($urandom);
    endcase
  endfunction

  task automatic send_mix(int items, int push_pct);
    repeat (items) begin
      if ($urandom_range(99) < push_pct)
        send_request(REQ_PUSH, pick_key(), HW'($urandom_range(16'hFFFF)));
      else
        send_request(REQ_POP, '0, '0);
    end
  endtask

  // Stops offering until every outstanding result has been transferred.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty pop, extreme keys and handles, ties, drain to empty.
    send_request(REQ_POP, '0, '0);
    send_request(REQ_PUSH, '1, '1);
    send_request(REQ_PUSH, '0, '0);
    send_request(REQ_PUSH, '0, 16'h1234);
    send_request(REQ_PUSH, 32'd5, 16'd7);
    send_request(REQ_PUSH, 32'd5, 16'd8);
    send_request(REQ_PUSH, 32'h8000_0000, 16'h8000);
    repeat (6) send_request(REQ_POP, '1, '1);
    send_request(REQ_POP, '0, '0);
    send_request(REQ_PUSH, 32'd9, 16'd1);
    send_request(REQ_PUSH, 32'd9, 16'd2);
    send_request(REQ_PUSH, 32'd9, 16'd3);
    send_request(REQ_PUSH, 32'd9, 16'd4);
    repeat (4) send_request(REQ_POP, '0, '0);
    drain_results();

    // Fill to capacity and past it, then drain past empty.
    send_mix(60, 80);
    while (sb.held < DEPTH) send_request(REQ_PUSH, pick_key(), HW'($urandom));
    repeat (4) send_request(REQ_PUSH, pick_key(), HW'($urandom));
    long_hold_req = 1'b1;
    send_mix(30, 50);
    drain_results();
    while (sb.held > 0) send_request(REQ_POP, '0, '0);
    repeat (3) send_request(REQ_POP, '0, '0);
    drain_results();

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      send_mix(60, 65);
      send_mix(50, 50);
      send_mix(50, 35);
      if (mode == 2) begin
        long_hold_req = 1'b1;
        send_mix(25, 60);
      end
      drain_results();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
src/bmhq_pkg.sv
src/bmhq_ram.sv
src/binary_min_heap_queue.sv
tb/binary_min_heap_queue_test.sv
